// File: hw/rtl/blac_pkg.sv
// ----------------------------------------------------------------------------
// blac_pkg
// Shared types, codes and the hash step for the advertising payload classifier.
// ----------------------------------------------------------------------------
package blac_pkg;

    // FNV-1a constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // AD structure types
    localparam logic [7:0] TYPE_MFG   = 8'hFF;
    localparam logic [7:0] TYPE_SVC16 = 8'h16;
    localparam logic [7:0] TYPE_SVC21 = 8'h21;

    // Company identifiers
    localparam logic [15:0] CID_CLASS_A   = 16'h004C;
    localparam logic [15:0] CID_CLASS_B_0 = 16'h00E0;
    localparam logic [15:0] CID_CLASS_B_1 = 16'h0075;
    localparam logic [15:0] CID_CLASS_B_2 = 16'h0006;

    // Service UUIDs
    localparam logic [15:0] UUID_CLASS_B_0 = 16'hFE2C;
    localparam logic [15:0] UUID_CLASS_B_1 = 16'hFE9F;
    localparam logic [15:0] UUID_CLASS_B_2 = 16'hFCF1;

    // Output bus widths
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [1:0] {
        KIND_GENERIC = 2'd0,
        KIND_CLASS_A = 2'd1,
        KIND_CLASS_B = 2'd2
    } kind_t;

    // One input request
    typedef struct packed {
        logic [7:0] adv_byte;
        logic       last_byte;
        logic       no_payload;
    } item_t;

    // One result request
    typedef struct packed {
        kind_t       device_kind;
        logic [31:0] fingerprint;
        logic        fingerprint_valid;
    } result_t;

    // Fold one byte into an FNV-1a hash; only the low word of the product counts
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// File: hw/rtl/blac_parser.sv
// ----------------------------------------------------------------------------
// blac_parser
// Walks the length-type-data structures one byte per cycle while advance is
// high and commits each structure's effect when its last byte arrives.
// ----------------------------------------------------------------------------
module blac_parser import blac_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    output logic    res_fire,
    output result_t res
);

    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  struct_length_reg, struct_length_next;
    logic [7:0]  struct_type_reg, struct_type_next;
    logic [7:0]  data_position_reg, data_position_next;
    logic [15:0] id_value_reg, id_value_next;
    logic [31:0] running_hash_reg, running_hash_next;
    kind_t       kind_committed_reg, kind_committed_next;
    logic [31:0] print_committed_reg, print_committed_next;
    logic        print_valid_reg, print_valid_next;
    logic        parse_stopped_reg, parse_stopped_next;

    logic ends;
    logic cid_a, cid_b, uuid_b, long_enough, hash_enough;

    assign ends = item.no_payload | item.last_byte;

    // Work out the next parse state and the result for the held byte
    always_comb begin
        bytes_left_next      = bytes_left_reg;
        struct_length_next   = struct_length_reg;
        struct_type_next     = struct_type_reg;
        data_position_next   = data_position_reg;
        id_value_next        = id_value_reg;
        running_hash_next    = running_hash_reg;
        kind_committed_next  = kind_committed_reg;
        print_committed_next = print_committed_reg;
        print_valid_next     = print_valid_reg;
        parse_stopped_next   = parse_stopped_reg;

        if (advance && !item.no_payload && !parse_stopped_reg) begin
            if (bytes_left_reg == 8'd0) begin
                // Length byte: zero stops the walk, otherwise open a structure
                if (item.adv_byte == 8'd0) begin
                    parse_stopped_next = 1'b1;
                end else begin
                    struct_length_next = item.adv_byte;
                    bytes_left_next    = item.adv_byte;
                    struct_type_next   = 8'd0;
                    data_position_next = 8'd0;
                    id_value_next      = 16'd0;
                    running_hash_next  = FNV_BASIS;
                end
            end else begin
                if (data_position_reg == 8'd0) begin
                    struct_type_next = item.adv_byte;
                end else begin
                    if (data_position_reg == 8'd1) begin
                        id_value_next = {id_value_reg[15:8], item.adv_byte};
                    end else if (data_position_reg == 8'd2) begin
                        id_value_next = {item.adv_byte, id_value_reg[7:0]};
                    end
                    running_hash_next = fnv_step(running_hash_reg, item.adv_byte);
                end
                if (data_position_reg != 8'hFF) begin
                    data_position_next = data_position_reg + 8'd1;
                end
                bytes_left_next = bytes_left_reg - 8'd1;
            end
        end

        // Commit a completed structure
        long_enough = struct_length_reg >= 8'd3;
        hash_enough = struct_length_reg >= 8'd4;
        cid_a  = id_value_next == CID_CLASS_A;
        cid_b  = id_value_next == CID_CLASS_B_0 || id_value_next == CID_CLASS_B_1
              || id_value_next == CID_CLASS_B_2;
        uuid_b = id_value_next == UUID_CLASS_B_0 || id_value_next == UUID_CLASS_B_1
              || id_value_next == UUID_CLASS_B_2;
        if (advance && !item.no_payload && !parse_stopped_reg
            && bytes_left_reg == 8'd1 && long_enough) begin
            if (struct_type_reg == TYPE_MFG) begin
                if (cid_a) begin
                    kind_committed_next = KIND_CLASS_A;
                end else if (cid_b) begin
                    kind_committed_next = KIND_CLASS_B;
                end
                if (hash_enough && !print_valid_reg) begin
                    print_committed_next = running_hash_next;
                    print_valid_next     = 1'b1;
                end
            end else if ((struct_type_reg == TYPE_SVC16 || struct_type_reg == TYPE_SVC21)
                         && kind_committed_reg == KIND_GENERIC && uuid_b) begin
                kind_committed_next = KIND_CLASS_B;
                if (hash_enough && !print_valid_reg) begin
                    print_committed_next = running_hash_next;
                    print_valid_next     = 1'b1;
                end
            end
        end

        // Build the result from the committed view
        res.device_kind       = kind_committed_next;
        res.fingerprint       = print_valid_next ? print_committed_next : 32'd0;
        res.fingerprint_valid = print_valid_next;
        res_fire              = advance && ends;

        // Return to the idle view after a result
        if (res_fire) begin
            bytes_left_next      = 8'd0;
            struct_length_next   = 8'd0;
            struct_type_next     = 8'd0;
            data_position_next   = 8'd0;
            id_value_next        = 16'd0;
            running_hash_next    = FNV_BASIS;
            kind_committed_next  = KIND_GENERIC;
            print_committed_next = 32'd0;
            print_valid_next     = 1'b0;
            parse_stopped_next   = 1'b0;
        end
    end

    // Hold the parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg      <= 8'd0;
            struct_length_reg   <= 8'd0;
            struct_type_reg     <= 8'd0;
            data_position_reg   <= 8'd0;
            id_value_reg        <= 16'd0;
            running_hash_reg    <= FNV_BASIS;
            kind_committed_reg  <= KIND_GENERIC;
            print_committed_reg <= 32'd0;
            print_valid_reg     <= 1'b0;
            parse_stopped_reg   <= 1'b0;
        end else begin
            bytes_left_reg      <= bytes_left_next;
            struct_length_reg   <= struct_length_next;
            struct_type_reg     <= struct_type_next;
            data_position_reg   <= data_position_next;
            id_value_reg        <= id_value_next;
            running_hash_reg    <= running_hash_next;
            kind_committed_reg  <= kind_committed_next;
            print_committed_reg <= print_committed_next;
            print_valid_reg     <= print_valid_next;
            parse_stopped_reg   <= parse_stopped_next;
        end
    end

endmodule

// File: hw/rtl/blac_out_reg.sv
// ----------------------------------------------------------------------------
// blac_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module blac_out_reg import blac_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [1:0] device_kind, [33:2] fingerprint
    output logic [0:0]           m_tuser   // [0] fingerprint_valid
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    // Take a new result or drop the delivered one
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 34){1'b0}}, res_reg.fingerprint, res_reg.device_kind};
    assign m_tuser  = res_reg.fingerprint_valid;

endmodule

// File: hw/rtl/ble_adv_classifier.sv
// ----------------------------------------------------------------------------
// ble_adv_classifier
// Advertising payload classifier: device kind and data fingerprint per payload.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle while it is not stalled: each byte
// is held in the input register while the structure walker updates its state
// and folds the byte into the FNV-1a hash (one multiply by the prime per byte),
// and the result of a payload is loaded into the output register when the
// walker takes its final byte from the input register; m_tvalid is driven by
// that output register. Input stalls only when a payload-ending request finds
// the output register still holding an untaken result.
module ble_adv_classifier import blac_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,  // [7:0] adv_byte
    input  logic                 s_tlast,  // last_byte
    input  logic [0:0]           s_tuser,  // [0] no_payload
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [1:0] device_kind, [33:2] fingerprint
    output logic [0:0]           m_tuser   // [0] fingerprint_valid
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    advance, out_free, res_fire, ends;
    result_t res;

    assign ends     = in_item_reg.no_payload | in_item_reg.last_byte;
    assign advance  = in_valid_reg && (!ends || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Hold the input request until the walker takes it
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.adv_byte   <= s_tdata;
            in_item_reg.last_byte  <= s_tlast;
            in_item_reg.no_payload <= s_tuser[0];
        end
    end

    blac_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_item_reg),
        .res_fire (res_fire),
        .res      (res)
    );

    blac_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_fire),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/blac_checker.sv
// ----------------------------------------------------------------------------
// blac_checker
// Port-level checks on the classifier's result stream.
// ----------------------------------------------------------------------------
module blac_checker import blac_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // No result survives a reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Fingerprint reads zero when none was captured
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[33:2] == 32'd0)
        else $error("fingerprint set without valid flag");

    // Kind is a known code and padding stays clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[M_TDATA_W-1:34] == '0)
        else $error("bad kind code or padding");

endmodule

bind ble_adv_classifier blac_checker u_blac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
